[hdl/lru_key_value_cache_defines.svh]
// Assertion helpers for the LRU key-value cache.
// Every assertion samples on aclk and is disabled while aresetn is low.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// When the condition holds, the consequence must hold in the same cycle.
`define LKVC_ASSERT_SAME(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (conseq)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define LKVC_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (conseq)) else $error(msg);

`endif

[hdl/lkvc_pkg.sv]
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_KEY_BITS    = 16;

    localparam int IN_KEY_BITS = 16;
    localparam int VALUE_BITS  = 32;
    localparam int CAP_BITS    = 5;
    localparam int PDATA_BITS  = 32;
    localparam int PADDR_BITS  = 2;

    localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } lkvc_op_t;

    typedef struct packed {
        lkvc_op_t                      opcode;
        logic [IN_KEY_BITS-1:0]        lookup_key;
        logic signed [VALUE_BITS-1:0]  write_value;
    } lkvc_req_t;

    typedef struct packed {
        logic                          hit;
        logic signed [VALUE_BITS-1:0]  read_value;
    } lkvc_rsp_t;

    localparam logic signed [VALUE_BITS-1:0] MISS_VALUE = '1;
    localparam logic signed [VALUE_BITS-1:0] PUT_VALUE  = '0;

endpackage

[hdl/lru_key_value_cache.sv]
`timescale 1ns / 1ps

// LRU key-value cache. A fully associative store of up to MAX_ENTRIES
// key/value pairs with least-recently-used replacement. Each transfer on the
// s_ channel is a get or a put; each produces exactly one transfer on the m_
// channel, in order. Throughput is one item per clock while m_ready keeps
// the output register drained: the item sits in an input register, parallel
// tag match and per-entry recency update decide the result and the new
// state, and the result lands in an output register, which drives m_valid.
// The per-entry tag compare and rank update set the cycle time. Recency is
// kept as a rank per entry (0 = most recent). The capacity register at byte
// address 0 (5 bits, reset 16) limits how many entries are held; a value of
// 0 acts as 1 and values above MAX_ENTRIES act as MAX_ENTRIES. Lowering it
// evicts nothing at once: each later put of a new key evicts one oldest
// entry. Entry valid bits clear at reset, so no clearing pass is needed.
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = lkvc_pkg::DEF_MAX_ENTRIES,
    parameter int KEY_BITS    = lkvc_pkg::DEF_KEY_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  lkvc_pkg::lkvc_req_t               s_data,

    output logic                              m_valid,
    input  logic                              m_ready,
    output lkvc_pkg::lkvc_rsp_t               m_data,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkvc_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [lkvc_pkg::PDATA_BITS-1:0]   pwdata,
    output logic [lkvc_pkg::PDATA_BITS-1:0]   prdata,
    output logic                              pready
);
    import lkvc_pkg::*;

    // Stored key width: only the low KEY_BITS of the 16-bit input key count.
    localparam int KW   = (KEY_BITS < IN_KEY_BITS) ? KEY_BITS : IN_KEY_BITS;
    localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW   = IW;
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

    // Byte address of the capacity register.
    localparam logic [PADDR_BITS-1:0] CAP_ADDR = '0;

    // ---------------------------------------------------------------
    // Configuration port: one register, at the capacity address.
    // ---------------------------------------------------------------
    logic [CAP_BITS-1:0] cap_reg;
    logic                cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == CAP_ADDR);
    assign prdata    = PDATA_BITS'(cap_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_write) begin
            cap_reg <= pwdata[CAP_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Handshake: input register feeds the single-pass logic, which
    // fires whenever the output register is free or being drained.
    // ---------------------------------------------------------------
    lkvc_req_t req_reg;
    logic      req_vld_reg;
    logic      req_vld_next;
    logic      out_vld_reg;
    logic      out_vld_next;
    logic      proc;
    logic      s_accept;

    assign proc     = req_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready  = !req_vld_reg || proc;
    assign s_accept = s_valid && s_ready;

    assign req_vld_next = s_accept || (req_vld_reg && !proc);
    assign out_vld_next = proc || (out_vld_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            req_vld_reg <= req_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture the incoming transfer; payload needs no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= s_data;
        end
    end

    // ---------------------------------------------------------------
    // Entry state
    // ---------------------------------------------------------------
    logic [KW-1:0]         key_reg   [MAX_ENTRIES];
    logic [VALUE_BITS-1:0] value_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [RW-1:0]         rank_reg  [MAX_ENTRIES];
    logic [RW-1:0]         rank_next [MAX_ENTRIES];
    logic [CW-1:0]         used_reg, used_next;

    // ---------------------------------------------------------------
    // Single-pass lookup and update
    // ---------------------------------------------------------------
    logic [KW-1:0]          in_key;
    logic                   is_put;
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] evict_vec;
    logic [MAX_ENTRIES-1:0] free_vec;
    logic                   hit;
    logic [IW-1:0]          hit_idx;
    logic [RW-1:0]          hit_rank;
    logic [IW-1:0]          slot_idx;
    logic                   slot_found;
    logic [CMPW-1:0]        cap_ext;
    logic [CMPW-1:0]        eff_cap;
    logic [CW-1:0]          used_m1;
    logic                   need_evict;

    assign in_key = req_reg.lookup_key[KW-1:0];
    assign is_put = (req_reg.opcode == OP_PUT);

    // Effective capacity: clamp to 1 .. MAX_ENTRIES.
    always_comb begin
        cap_ext = CMPW'(cap_reg);
        if (cap_ext == '0) begin
            eff_cap = CMPW'(1);
        end else if (cap_ext > CMPW'(MAX_ENTRIES)) begin
            eff_cap = CMPW'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign used_m1 = used_reg - CW'(1);

    // Tag match, hit index and rank of the hit entry.
    always_comb begin
        hit_idx  = '0;
        hit_rank = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            match_vec[i] = valid_reg[i] && (key_reg[i] == in_key);
            if (match_vec[i]) begin
                hit_idx  = hit_idx | IW'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
        end
        hit = |match_vec;
    end

    // The oldest valid entry holds rank used-1; evict it on a full put miss.
    assign need_evict = is_put && !hit && (CMPW'(used_reg) >= eff_cap);

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            evict_vec[i] = need_evict && valid_reg[i] && (rank_reg[i] == used_m1[RW-1:0]);
            free_vec[i]  = !valid_reg[i] || evict_vec[i];
        end
    end

    // Lowest free entry takes the new key.
    always_comb begin
        slot_idx   = '0;
        slot_found = 1'b0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                slot_idx   = IW'(i);
                slot_found = 1'b1;
            end
        end
    end

    // Next valid bits, ranks and fill count.
    always_comb begin
        valid_next = valid_reg;
        used_next  = used_reg;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_next[i] = rank_reg[i];
        end
        if (proc) begin
            if (hit) begin
                // Promote the hit entry; the more recent ones age by one.
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (match_vec[i]) begin
                        rank_next[i] = '0;
                    end else if (valid_reg[i] && (rank_reg[i] < hit_rank)) begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                end
            end else if (is_put) begin
                // Drop the victim, age every survivor, insert as most recent.
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (evict_vec[i]) begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end else if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + RW'(1);
                    end
                    if (slot_found && (slot_idx == IW'(i))) begin
                        valid_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                end
                if (need_evict && !slot_found) begin
                    used_next = used_reg - CW'(1);
                end else if (!need_evict && slot_found) begin
                    used_next = used_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            used_reg  <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            valid_reg <= valid_next;
            used_reg  <= used_next;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Key tags: written only when a new entry is inserted.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (proc && is_put && !hit && slot_found && (slot_idx == IW'(i))) begin
                key_reg[i] <= in_key;
            end
        end
    end

    // Value store: one write port (put) and one registered read port (get).
    always_ff @(posedge aclk) begin
        if (proc && is_put) begin
            if (hit) begin
                value_mem[hit_idx] <= req_reg.write_value;
            end else if (slot_found) begin
                value_mem[slot_idx] <= req_reg.write_value;
            end
        end
    end

    // Result register; the value read comes straight out of the store.
    lkvc_rsp_t rsp_reg;

    always_ff @(posedge aclk) begin
        if (proc) begin
            rsp_reg.hit <= hit;
            if (is_put) begin
                rsp_reg.read_value <= PUT_VALUE;
            end else if (hit) begin
                rsp_reg.read_value <= value_mem[hit_idx];
            end else begin
                rsp_reg.read_value <= MISS_VALUE;
            end
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = rsp_reg;

endmodule

[hdl/lkvc_checker.sv]
`timescale 1ns / 1ps

`include "lru_key_value_cache_defines.svh"

module lkvc_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  lkvc_pkg::lkvc_req_t               s_data,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  lkvc_pkg::lkvc_rsp_t               m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [lkvc_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [lkvc_pkg::PDATA_BITS-1:0]   pwdata,
    input  logic [lkvc_pkg::PDATA_BITS-1:0]   prdata,
    input  logic                              pready
);
    import lkvc_pkg::*;

    // A miss result is either a get miss (-1) or a put of a new key (0).
    `LKVC_ASSERT_SAME(a_miss_value, m_valid && !m_data.hit, (m_data.read_value == MISS_VALUE) || (m_data.read_value == PUT_VALUE), "miss result carries a stored value")

    // A capacity write reads back on the next cycle.
    `LKVC_ASSERT_NEXT(a_cap_readback, psel && penable && pwrite && pready, prdata[CAP_BITS-1:0] == $past(pwdata[CAP_BITS-1:0]), "capacity register did not take the write")

    // The upper read data bits never carry anything.
    `LKVC_ASSERT_SAME(a_prdata_upper, psel, prdata[PDATA_BITS-1:CAP_BITS] == '0, "capacity read has stray upper bits")

    // A stalled result transfer holds its payload.
    `LKVC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

[bench/lru_cache_checker.sv]
`timescale 1ns / 1ps

module lru_cache_checker #(
    parameter int                               MAX_ENTRIES = lkvc_pkg::DEF_MAX_ENTRIES,
    parameter int                               KEY_BITS    = lkvc_pkg::DEF_KEY_BITS,
    parameter logic [lkvc_pkg::PADDR_BITS-1:0]  CAP_ADDR    = '0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  lkvc_pkg::lkvc_req_t              s_data,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  lkvc_pkg::lkvc_rsp_t              m_data,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [lkvc_pkg::PADDR_BITS-1:0]  paddr,
    input  logic [lkvc_pkg::PDATA_BITS-1:0]  pwdata,
    output int                               fail_count,
    output int                               pending
);
    import lkvc_pkg::*;

    logic [KEY_BITS-1:0]          tag_store  [MAX_ENTRIES];
    logic signed [VALUE_BITS-1:0] data_store [MAX_ENTRIES];
    bit                           slot_valid [MAX_ENTRIES];
    int unsigned                  age_rank   [MAX_ENTRIES];
    int unsigned                  fill_count;
    logic [CAP_BITS-1:0]          capacity_reg;
    lkvc_rsp_t                    expected_rsp_q [$];
    int                           rsp_index;

    assign pending = expected_rsp_q.size();

    initial begin
        fail_count = 0;
        rsp_index  = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: result %0d mismatch on %s: got %h, expected %h",
                 $time, rsp_index, what, got, want);
        fail_count++;
    endtask

    // Apply one get or put to the shadow store and return its response.
    function automatic lkvc_rsp_t lru_apply(input lkvc_req_t req);
        logic [KEY_BITS-1:0] key;
        int                  found;
        int                  victim;
        int                  slot;
        int unsigned         eff_cap;
        int unsigned         old_rank;
        lkvc_rsp_t           rsp;
        key   = req.lookup_key[KEY_BITS-1:0];
        found = -1;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (found < 0 && slot_valid[i] && tag_store[i] == key) begin
                found = i;
            end
        end
        eff_cap = (capacity_reg == 0) ? 1 :
                  (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : capacity_reg;
        if (found >= 0) begin
            // promote to most recent; entries younger than it age by one
            old_rank = age_rank[found];
            for (int j = 0; j < MAX_ENTRIES; j++) begin
                if (slot_valid[j] && age_rank[j] < old_rank) begin
                    age_rank[j]++;
                end
            end
            age_rank[found] = 0;
            rsp.hit = 1'b1;
            if (req.opcode == OP_GET) begin
                rsp.read_value = data_store[found];
            end else begin
                data_store[found] = req.write_value;
                rsp.read_value    = PUT_VALUE;
            end
        end else begin
            rsp.hit        = 1'b0;
            rsp.read_value = (req.opcode == OP_GET) ? MISS_VALUE : PUT_VALUE;
            if (req.opcode == OP_PUT) begin
                if (fill_count >= eff_cap) begin
                    victim = -1;
                    for (int j = 0; j < MAX_ENTRIES; j++) begin
                        if (slot_valid[j] &&
                            (victim < 0 || age_rank[j] > age_rank[victim])) begin
                            victim = j;
                        end
                    end
                    if (victim >= 0) begin
                        slot_valid[victim] = 1'b0;
                        age_rank[victim]   = 0;
                        if (fill_count > 0) fill_count--;
                    end
                end
                slot = -1;
                for (int j = 0; j < MAX_ENTRIES; j++) begin
                    if (slot < 0 && !slot_valid[j]) slot = j;
                end
                if (slot >= 0) begin
                    for (int j = 0; j < MAX_ENTRIES; j++) begin
                        if (slot_valid[j]) age_rank[j]++;
                    end
                    tag_store[slot]  = key;
                    data_store[slot] = req.write_value;
                    slot_valid[slot] = 1'b1;
                    age_rank[slot]   = 0;
                    fill_count++;
                end
            end
        end
        return rsp;
    endfunction

    always @(posedge aclk) begin
        lkvc_rsp_t want;
        if (!aresetn) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                tag_store[i]  = '0;
                data_store[i] = '0;
                slot_valid[i] = 1'b0;
                age_rank[i]   = 0;
            end
            fill_count   = 0;
            capacity_reg = CAP_RESET;
            expected_rsp_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("unrequested response", m_data.read_value, '0);
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (m_data.hit !== want.hit) begin
                        report_mismatch("hit", m_data.hit, want.hit);
                    end
                    if (m_data.read_value !== want.read_value) begin
                        report_mismatch("read_value", m_data.read_value, want.read_value);
                    end
                end
                rsp_index++;
            end
            if (s_valid && s_ready) begin
                expected_rsp_q.push_back(lru_apply(s_data));
            end
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR) begin
                capacity_reg = pwdata[CAP_BITS-1:0];
            end
        end
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import lkvc_pkg::*;

    // Capacity register sits at byte address 0.
    localparam logic [PADDR_BITS-1:0] CAPACITY_ADDR = '0;
    // Input and output registers; pad a little beyond them before touching config.
    localparam int SETTLE_CYCLES = 6;
    // Receiver stall long enough to back the pipeline up into s_ready.
    localparam int RX_HOLD_CYCLES = 400;
    localparam int RX_HOLD_AFTER  = 600;
    localparam int CYCLE_LIMIT    = 300000;
    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 140;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    lkvc_req_t              s_data;
    logic                   m_valid;
    logic                   m_ready;
    lkvc_rsp_t              m_data;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_BITS-1:0]  paddr;
    logic [PDATA_BITS-1:0]  pwdata;
    logic [PDATA_BITS-1:0]  prdata;
    logic                   pready;

    int  fail_count;
    int  pending;
    int  cycle_count;
    bit  tx_idle;
    bit  rx_idle;

    lru_key_value_cache uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lru_cache_checker #(
        .CAP_ADDR (CAPACITY_ADDR)
    ) checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Response side: draw a stall per transfer, and once, after enough
    // responses, hold m_ready low for a long stretch while the sender keeps
    // pushing, so the pipeline fills and s_ready drops.
    initial begin
        int gap;
        int rsp_seen;
        m_ready  = 1'b0;
        rsp_seen = 0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rsp_seen == RX_HOLD_AFTER) begin
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end
            gap = rx_idle ? $urandom_range(0, 4) : 0;
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            // wait for the transfer; sample at the rising edge
            do @(posedge aclk); while (!(m_valid && m_ready));
            rsp_seen++;
            @(negedge aclk);
        end
    end

    // Offer one request, holding valid and payload until the transfer.
    task automatic send_item(input lkvc_op_t op, input logic [IN_KEY_BITS-1:0] key,
                             input logic [VALUE_BITS-1:0] value);
        int gap;
        lkvc_req_t req;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        req.opcode      = op;
        req.lookup_key  = key;
        req.write_value = value;
        s_data  <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Drop valid, let every outstanding response come back, then settle.
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Two-phase register write: setup, then access until pready.
    task automatic write_capacity(input logic [PDATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAPACITY_ADDR;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int                      cap_plan [PHASES];
        logic [IN_KEY_BITS-1:0]  key_pool [24];
        logic [IN_KEY_BITS-1:0]  key;
        logic [VALUE_BITS-1:0]   value;
        lkvc_op_t                op;
        int                      pool_n;

        // Capacities per random phase: the register extremes (0 and 31 act
        // as 1 and 16), the in-range ends, and shrinking below fill level.
        cap_plan = '{16, 1, 0, 31, 4, 17, 2, 8, 15, 3};

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty miss, key and value extremes, put hit, get that
        // hits a stored -1, value ignored on get, at reset capacity.
        send_item(OP_GET, 16'h0000, 32'h0000_0000);
        send_item(OP_PUT, 16'h0000, 32'h7FFF_FFFF);
        send_item(OP_PUT, 16'hFFFF, 32'h8000_0000);
        send_item(OP_GET, 16'h0000, 32'h0000_0000);
        send_item(OP_GET, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(OP_PUT, 16'h0000, 32'hFFFF_FFFF);
        send_item(OP_GET, 16'h0000, 32'h0000_0000);
        send_item(OP_GET, 16'h5A5A, 32'h0000_0000);
        send_item(OP_PUT, 16'h5A5A, 32'h0000_0000);
        send_item(OP_PUT, 16'hA5A5, 32'h1234_5678);
        drain_pipeline();

        // Shrink below the fill level: each new key evicts only one.
        write_capacity(32'd2);
        send_item(OP_PUT, 16'h1234, 32'hABCD_0000);
        send_item(OP_GET, 16'hFFFF, 32'h0000_0000);
        send_item(OP_GET, 16'h0000, 32'h0000_0000);
        send_item(OP_GET, 16'h5A5A, 32'h0000_0000);
        send_item(OP_GET, 16'hA5A5, 32'h0000_0000);
        send_item(OP_GET, 16'h1234, 32'h0000_0000);
        drain_pipeline();

        write_capacity(32'd1);
        send_item(OP_PUT, 16'h4321, 32'h0000_0001);
        send_item(OP_GET, 16'h1234, 32'h0000_0000);
        send_item(OP_GET, 16'h4321, 32'h0000_0000);
        send_item(OP_PUT, 16'h4321, 32'h0000_0002);
        send_item(OP_GET, 16'h4321, 32'h0000_0000);
        drain_pipeline();

        // Random phases: keys mostly from a small pool so hits, updates
        // and evictions are common; a few stray keys for noise.
        for (int phase = 0; phase < PHASES; phase++) begin
            // last phase also sets junk upper bits the register must drop
            write_capacity((phase == PHASES - 1) ? (32'hFFFF_FFE0 | cap_plan[phase])
                                                 : cap_plan[phase]);
            tx_idle = (phase % 3 != 2);
            rx_idle = (phase % 4 != 3);
            pool_n  = $urandom_range(2, 24);
            for (int i = 0; i < 24; i++) begin
                key_pool[i] = IN_KEY_BITS'($urandom);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op  = ($urandom_range(0, 1) != 0) ? OP_PUT : OP_GET;
                key = ($urandom_range(0, 9) == 0) ? IN_KEY_BITS'($urandom)
                                                  : key_pool[$urandom_range(0, pool_n - 1)];
                case ($urandom_range(0, 7))
                    0:       value = 32'h8000_0000;
                    1:       value = 32'h7FFF_FFFF;
                    2:       value = 32'hFFFF_FFFF;
                    default: value = $urandom;
                endcase
                send_item(op, key, value);
            end
            drain_pipeline();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
